### design/bsfk_pkg.sv
// Shared types, constants and a helper function of the box spline footprint kernel.
package bsfk_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COS_W     = 17;
    localparam int REG_W     = 24;
    localparam int OUT_W     = 32;
    localparam int WIDE_W    = 192;
    localparam int ACC_W     = 128;
    localparam int Q_W       = 41;
    localparam int LIMB_W    = 32;
    localparam int LIMBS     = WIDE_W / LIMB_W;
    localparam int CNT_W     = 8;
    localparam int SHIFT_W   = 27;
    localparam int W_W       = 43;
    localparam int PROD_W    = LIMB_W + REG_W;

    localparam logic [REG_W-1:0] ONE_VAL   = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [Q_W-1:0]   RATIO_MAX = Q_W'((64'd1 << (FRAC_BITS + 6)) - 64'd1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_PIXEL_STEP     = 2'd0;
    localparam logic [1:0] CFG_DETECTOR_WIDTH = 2'd1;
    localparam logic [1:0] CFG_KERNEL_MODE    = 2'd2;

    // Kernel mode codes.
    localparam logic MODE_FOOTPRINT = 1'b0;
    localparam logic MODE_BLUR      = 1'b1;

    typedef struct packed {
        logic [REG_W-1:0] pixel_step;
        logic [REG_W-1:0] detector_width;
        logic             kernel_mode;
    } cfg_t;

    typedef struct packed {
        logic [COS_W-1:0] abs_cosine;
        logic [COS_W-1:0] abs_sine;
        logic [REG_W-1:0] distance;
        logic             both;
        logic             beyond;
    } job_t;

    // First box step times the factorial of the spline degree 2n-1 (1, 6 or 120).
    // The first step is a 17-bit direction value or 1.0, so the product fits.
    function automatic logic [REG_W-1:0] fact_times(input logic [1:0] n,
                                                    input logic [REG_W-1:0] h);
        logic [REG_W-1:0] v;
        case (n)
            2'd2:    v = (h << 2) + (h << 1);
            2'd3:    v = (h << 7) - (h << 3);
            default: v = h;
        endcase
        return v;
    endfunction

endpackage

### design/bsfk_in_if.sv
// Input channel carrying one kernel evaluation request per word.
interface bsfk_in_if;
    logic                           valid;
    logic                           ready;
    logic [bsfk_pkg::COS_W-1:0]     abs_cosine;
    logic [bsfk_pkg::COS_W-1:0]     abs_sine;
    logic [bsfk_pkg::REG_W-1:0]     distance;
    logic [bsfk_pkg::REG_W-1:0]     support_half_width;

    modport source (output valid, abs_cosine, abs_sine, distance, support_half_width,
                    input ready);
    modport sink   (input valid, abs_cosine, abs_sine, distance, support_half_width,
                    output ready);
endinterface

### design/bsfk_out_if.sv
// Output channel carrying one kernel value per word.
interface bsfk_out_if;
    logic                           valid;
    logic                           ready;
    logic [bsfk_pkg::OUT_W-1:0]     kernel_value;

    modport source (output valid, kernel_value, input ready);
    modport sink   (input valid, kernel_value, output ready);
endinterface

### design/bsfk_front.sv
// Front end: classifies each incoming word and pushes a job into the queue.
module bsfk_front (
    bsfk_in_if.sink          item,
    output logic             push_valid,
    input  logic             push_ready,
    output bsfk_pkg::job_t   push_data
);

    // Support test and direction class are settled here so the back end only computes.
    always_comb
    begin
        push_data.abs_cosine = item.abs_cosine;
        push_data.abs_sine   = item.abs_sine;
        push_data.distance   = item.distance;
        push_data.both       = (item.abs_cosine != '0) && (item.abs_sine != '0);
        push_data.beyond     = item.distance > item.support_half_width;
    end

    assign push_valid = item.valid;
    assign item.ready = push_ready;

endmodule

### design/bsfk_queue.sv
// Small job queue between the front end and the back end.
module bsfk_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  bsfk_pkg::job_t   push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output bsfk_pkg::job_t   pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsfk_pkg::job_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/bsfk_back.sv
// Back end: sequencer with a bit-serial divider and a limb-serial multiplier.
module bsfk_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bsfk_pkg::cfg_t   cfg,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  bsfk_pkg::job_t   pop_data,
    bsfk_out_if.source       result
);

    localparam int REG_W  = bsfk_pkg::REG_W;
    localparam int WIDE_W = bsfk_pkg::WIDE_W;
    localparam int ACC_W  = bsfk_pkg::ACC_W;
    localparam int Q_W    = bsfk_pkg::Q_W;
    localparam int LW     = bsfk_pkg::LIMB_W;
    localparam int CNT_W  = bsfk_pkg::CNT_W;
    localparam int SH_W   = bsfk_pkg::SHIFT_W;
    localparam int W_W    = bsfk_pkg::W_W;
    localparam int PROD_W = bsfk_pkg::PROD_W;
    localparam int OUT_W  = bsfk_pkg::OUT_W;
    localparam int F      = bsfk_pkg::FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVQ, S_DIVR, S_TINIT, S_TMUL, S_TADD, S_NEXT,
        S_SMUL, S_SSHIFT, S_DIVF, S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]          out_value_reg, out_value_next;
    bsfk_pkg::job_t            job_reg, job_next;
    logic [Q_W-1:0]            q_reg, q_next;
    logic [REG_W-1:0]          h0_reg, h0_next, h1_reg, h1_next, h2_reg, h2_next;
    logic [1:0]                n_reg, n_next;
    logic [WIDE_W-1:0]         m_reg, m_next;
    logic [REG_W:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [2:0]                limb_reg, limb_next;
    logic [REG_W-1:0]          carry_reg, carry_next;
    logic [REG_W-1:0]          factor_reg, factor_next;
    logic [REG_W-1:0]          divisor_reg, divisor_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [1:0]                d0_reg, d0_next, d1_reg, d1_next, d2_reg, d2_next;
    logic [2:0]                pow_reg, pow_next;
    logic [2:0]                didx_reg, didx_next;
    logic [OUT_W-1:0]          res_reg, res_next;

    logic [REG_W-1:0]          x_eff;
    logic [REG_W:0]            rem_sh;
    logic                      div_ge;
    logic [WIDE_W-1:0]         div_m;
    logic [REG_W:0]            div_rem;
    logic                      div_last;
    logic [PROD_W-1:0]         prod;
    logic [WIDE_W-1:0]         mul_m;
    logic                      mul_last;
    logic [Q_W-1:0]            r_q;
    logic [Q_W-1:0]            r_val;
    logic [REG_W-1:0]          hs0, hs1, hs2;
    logic [1:0]                ns;
    logic signed [SH_W-1:0]    shift;
    logic [1:0]                zeros;
    logic signed [W_W-1:0]     w_s;
    logic                      w_pos;
    logic [2:0]                pow_init;
    logic signed [ACC_W-1:0]   term;
    logic                      odo_done;
    logic [1:0]                d0_adv, d1_adv, d2_adv;
    logic [2:0]                didx_last;

    // Signed offset of one box for digit 0 (-h), 1 (centre) or 2 (+h).
    function automatic logic signed [SH_W-1:0] box_off(input logic [1:0] d,
                                                       input logic [REG_W-1:0] h,
                                                       input logic active);
        logic signed [SH_W-1:0] hv;
        logic signed [SH_W-1:0] o;
        hv = $signed({{(SH_W - REG_W){1'b0}}, h});
        o  = '0;
        if (active && d == 2'd0)
        begin
            o = -hv;
        end
        else if (active && d == 2'd2)
        begin
            o = hv;
        end
        return o;
    endfunction

    assign x_eff = (cfg.pixel_step == '0) ? REG_W'(1) : cfg.pixel_step;

    // One restoring division step on the working register.
    always_comb
    begin
        rem_sh   = {rem_reg[REG_W-1:0], m_reg[WIDE_W-1]};
        div_ge   = rem_sh >= {1'b0, divisor_reg};
        div_m    = {m_reg[WIDE_W-2:0], div_ge};
        div_rem  = div_ge ? rem_sh - {1'b0, divisor_reg} : rem_sh;
        div_last = cnt_reg == CNT_W'(WIDE_W - 1);
    end

    // One limb of a multiply by a 24-bit factor; the register rotates by a limb.
    always_comb
    begin
        prod     = PROD_W'(m_reg[LW-1:0]) * PROD_W'(factor_reg) + PROD_W'(carry_reg);
        mul_m    = {prod[LW-1:0], m_reg[WIDE_W-1:LW]};
        mul_last = limb_reg == 3'(bsfk_pkg::LIMBS - 1);
    end

    // Blur ratio clamp and box step selection.
    always_comb
    begin
        r_q = div_m[Q_W-1:0];
        if ((|div_m[WIDE_W-1:Q_W]) || r_q > bsfk_pkg::RATIO_MAX)
        begin
            r_val = bsfk_pkg::RATIO_MAX;
        end
        else if (r_q == '0)
        begin
            r_val = Q_W'(1);
        end
        else
        begin
            r_val = r_q;
        end

        hs0 = bsfk_pkg::ONE_VAL;
        hs1 = r_val[REG_W-1:0];
        hs2 = r_val[REG_W-1:0];
        ns  = 2'd1;
        if (cfg.kernel_mode == bsfk_pkg::MODE_FOOTPRINT)
        begin
            if (job_reg.both)
            begin
                hs0 = REG_W'(job_reg.abs_cosine);
                hs1 = REG_W'(job_reg.abs_sine);
                ns  = 2'd2;
            end
        end
        else
        begin
            if (job_reg.both)
            begin
                hs0 = REG_W'(job_reg.abs_cosine);
                hs1 = REG_W'(job_reg.abs_sine);
                ns  = 2'd3;
            end
            else
            begin
                ns  = 2'd2;
            end
        end
    end

    // Shift, weight and argument of the current truncated-power term.
    always_comb
    begin
        shift = box_off(d0_reg, h0_reg, 1'b1) + box_off(d1_reg, h1_reg, n_reg >= 2'd2)
              + box_off(d2_reg, h2_reg, n_reg == 2'd3);
        zeros = 2'(d0_reg == 2'd1) + 2'((n_reg >= 2'd2) && (d1_reg == 2'd1))
              + 2'((n_reg == 2'd3) && (d2_reg == 2'd1));
        w_s   = -$signed({{(W_W - SH_W){shift[SH_W-1]}}, shift})
              - $signed({{(W_W - Q_W){1'b0}}, q_reg});
        w_pos = !w_s[W_W-1] && (w_s != '0);
        case (n_reg)
            2'd2:    pow_init = 3'd2;
            2'd3:    pow_init = 3'd4;
            default: pow_init = 3'd0;
        endcase
        term = $signed(m_reg[ACC_W-1:0] << zeros);
    end

    // Base-3 odometer over the active boxes.
    always_comb
    begin
        d0_adv   = d0_reg;
        d1_adv   = d1_reg;
        d2_adv   = d2_reg;
        odo_done = 1'b0;
        if (d0_reg != 2'd2)
        begin
            d0_adv = d0_reg + 2'd1;
        end
        else
        begin
            d0_adv = 2'd0;
            if (n_reg == 2'd1)
            begin
                odo_done = 1'b1;
            end
            else if (d1_reg != 2'd2)
            begin
                d1_adv = d1_reg + 2'd1;
            end
            else
            begin
                d1_adv = 2'd0;
                if (n_reg == 2'd2)
                begin
                    odo_done = 1'b1;
                end
                else if (d2_reg != 2'd2)
                begin
                    d2_adv = d2_reg + 2'd1;
                end
                else
                begin
                    odo_done = 1'b1;
                end
            end
        end
        didx_last = {n_reg, 1'b0} - 3'd1;
    end

    // Divisor chain of the final scaling: the first step times the factorial, that step
    // once more, then each further step twice.
    function automatic logic [REG_W-1:0] div_sel(input logic [2:0] idx,
                                                 input logic [1:0] n,
                                                 input logic [REG_W-1:0] a,
                                                 input logic [REG_W-1:0] b,
                                                 input logic [REG_W-1:0] c);
        logic [REG_W-1:0] v;
        case (idx)
            3'd1:       v = a;
            3'd2, 3'd3: v = b;
            3'd4, 3'd5: v = c;
            default:    v = bsfk_pkg::fact_times(n, a);
        endcase
        return v;
    endfunction

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        job_next       = job_reg;
        q_next         = q_reg;
        h0_next        = h0_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        limb_next      = limb_reg;
        carry_next     = carry_reg;
        factor_next    = factor_reg;
        divisor_next   = divisor_reg;
        acc_next       = acc_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        pow_next       = pow_reg;
        didx_next      = didx_reg;
        res_next       = res_reg;
        pop_ready      = 1'b0;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    job_next     = pop_data;
                    m_next       = WIDE_W'(pop_data.distance) << F;
                    rem_next     = '0;
                    cnt_next     = '0;
                    divisor_next = x_eff;
                    res_next     = '0;
                    state_next   = pop_data.beyond ? S_DONE : S_DIVQ;
                end
            end
            S_DIVQ, S_DIVR:
            begin
                m_next   = div_m;
                rem_next = div_rem;
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    if (state_reg == S_DIVQ)
                    begin
                        q_next = div_m[Q_W-1:0];
                    end
                    if (state_reg == S_DIVQ && cfg.kernel_mode == bsfk_pkg::MODE_BLUR)
                    begin
                        m_next     = WIDE_W'(cfg.detector_width) << F;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = S_DIVR;
                    end
                    else
                    begin
                        h0_next    = hs0;
                        h1_next    = hs1;
                        h2_next    = hs2;
                        n_next     = ns;
                        d0_next    = '0;
                        d1_next    = '0;
                        d2_next    = '0;
                        acc_next   = '0;
                        state_next = S_TINIT;
                    end
                end
            end
            S_TINIT:
            begin
                m_next      = WIDE_W'(w_s[REG_W-1:0]);
                factor_next = w_s[REG_W-1:0];
                pow_next    = pow_init;
                limb_next   = '0;
                carry_next  = '0;
                if (!w_pos)
                begin
                    state_next = S_NEXT;
                end
                else if (pow_init == '0)
                begin
                    state_next = S_TADD;
                end
                else
                begin
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                m_next     = mul_m;
                carry_next = prod[PROD_W-1:LW];
                limb_next  = limb_reg + 1'b1;
                if (mul_last)
                begin
                    limb_next  = '0;
                    carry_next = '0;
                    pow_next   = pow_reg - 1'b1;
                    if (pow_reg == 3'd1)
                    begin
                        state_next = S_TADD;
                    end
                end
            end
            S_TADD:
            begin
                // Terms with an odd number of centre taps carry weight -2^k.
                acc_next   = zeros[0] ? acc_reg - term : acc_reg + term;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                d0_next = d0_adv;
                d1_next = d1_adv;
                d2_next = d2_adv;
                if (!odo_done)
                begin
                    state_next = S_TINIT;
                end
                else if (acc_reg[ACC_W-1] || acc_reg == '0)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    m_next      = WIDE_W'(acc_reg);
                    factor_next = x_eff;
                    limb_next   = '0;
                    carry_next  = '0;
                    state_next  = S_SMUL;
                end
            end
            S_SMUL:
            begin
                m_next     = mul_m;
                carry_next = prod[PROD_W-1:LW];
                limb_next  = limb_reg + 1'b1;
                if (mul_last)
                begin
                    state_next = S_SSHIFT;
                end
            end
            S_SSHIFT:
            begin
                m_next       = m_reg << F;
                didx_next    = '0;
                divisor_next = div_sel(3'd0, n_reg, h0_reg, h1_reg, h2_reg);
                rem_next     = '0;
                cnt_next     = '0;
                state_next   = S_DIVF;
            end
            S_DIVF:
            begin
                m_next   = div_m;
                rem_next = div_rem;
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    if (didx_reg == didx_last)
                    begin
                        res_next   = (|div_m[WIDE_W-1:OUT_W]) ? '1 : div_m[OUT_W-1:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        didx_next    = didx_reg + 1'b1;
                        divisor_next = div_sel(didx_reg + 1'b1, n_reg, h0_reg, h1_reg,
                                               h2_reg);
                        rem_next     = '0;
                        cnt_next     = '0;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        job_reg       <= job_next;
        q_reg         <= q_next;
        h0_reg        <= h0_next;
        h1_reg        <= h1_next;
        h2_reg        <= h2_next;
        n_reg         <= n_next;
        m_reg         <= m_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        limb_reg      <= limb_next;
        carry_reg     <= carry_next;
        factor_reg    <= factor_next;
        divisor_reg   <= divisor_next;
        acc_reg       <= acc_next;
        d0_reg        <= d0_next;
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        pow_reg       <= pow_next;
        didx_reg      <= didx_next;
        res_reg       <= res_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.kernel_value = out_value_reg;

endmodule

### design/box_spline_footprint_kernel.sv
// Top level of the box spline footprint kernel: registers, front end, queue and back end.
// The block accepts request words into a queue of QUEUE_DEPTH entries and evaluates them
// one at a time in the back end, whose time per word is set by a one-bit-per-cycle divider
// over a 192-bit working register and a 32x24 limb multiplier. A word beyond the support
// is popped and yields zero without any arithmetic. Otherwise, with n boxes (1, 2 or 3)
// and p = 2n-1, a word leaves the queue, gets its distance quotient and, in blur mode,
// the detector ratio; then each of the 3^n terms is skipped if it vanishes, or raised to
// the power p by p-1 limb-serial multiplies if it is live; then come the pixel step
// scaling, a final chain of 2n divisions (the factorial is folded into the first divisor)
// and the hand-over of the value to the output register. The scaling and division are
// skipped when the sum is not positive.
// A finished value waits in an output register while the next word is already in work.
module box_spline_footprint_kernel #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [bsfk_pkg::REG_W-1:0]   cfg_data,
    bsfk_in_if.sink                      item,
    bsfk_out_if.source                   result
);

    bsfk_pkg::cfg_t   cfg_reg, cfg_next;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    bsfk_pkg::job_t   push_data, pop_data;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bsfk_pkg::CFG_PIXEL_STEP:     cfg_next.pixel_step     = cfg_data;
                bsfk_pkg::CFG_DETECTOR_WIDTH: cfg_next.detector_width = cfg_data;
                bsfk_pkg::CFG_KERNEL_MODE:    cfg_next.kernel_mode    = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_step     <= bsfk_pkg::ONE_VAL;
            cfg_reg.detector_width <= bsfk_pkg::ONE_VAL;
            cfg_reg.kernel_mode    <= bsfk_pkg::MODE_FOOTPRINT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bsfk_front u_front (
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bsfk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bsfk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

### design/bsfk_checker.sv
// Port-level checker for the box spline footprint kernel and its bind statement.
module bsfk_checker #(
    parameter int DEPTH = 4
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bsfk_pkg::OUT_W-1:0]  kernel_value
);

    logic [7:0] pending_reg, pending_next;

    // Words accepted but not yet delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pending_next = pending_reg + 8'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_value_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(kernel_value))
        else $error("result value changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> pending_reg != 8'd0)
        else $error("result delivered without an accepted request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 8'(DEPTH + 2))
        else $error("more words in flight than queue and back end can hold");

endmodule

bind box_spline_footprint_kernel bsfk_checker #(
    .DEPTH (QUEUE_DEPTH)
) u_bsfk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .kernel_value (result.kernel_value)
);
